// ===== rtl/core/abd_pkg.sv =====
// Package: shared types, constants and predictor taps for the ADPCM block decoder.
`default_nettype none
package abd_pkg;

  localparam int unsigned POS_W   = 4;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned FILT_W  = 3;
  localparam int unsigned TAP_W   = 8;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned PROD_W  = SAMP_W + TAP_W;
  localparam int unsigned PRED_SH = 6;
  localparam int unsigned SUM_W   = 20;

  // Block layout
  localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
  localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST   = 4'd15;

  localparam logic [FILT_W-1:0] FILT_MAX  = 3'd4;

  // Command codes
  localparam logic CMD_STREAM  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Saturation limits
  localparam logic signed [SUM_W-1:0]  SUM_MAX     = 20'sd32767;
  localparam logic signed [SUM_W-1:0]  SUM_MIN     = -20'sd32768;
  localparam logic signed [SAMP_W-1:0] SAMP_MAX    = 16'sh7fff;
  localparam logic signed [SAMP_W-1:0] SAMP_MIN    = 16'sh8000;
  localparam logic signed [SAMP_W-1:0] SAMP_OUT_MIN = 16'sh8001;

  typedef enum logic [1:0] {
    END_CONTINUE = 2'd0,
    END_STOP     = 2'd1,
    END_LOOP     = 2'd2
  } abd_end_t;

  // One data byte waiting for its two nibbles to be decoded
  typedef struct packed {
    logic                valid;
    logic                phase;
    logic [7:0]          data;
    logic [SHIFT_W-1:0]  shift;
    logic [FILT_W-1:0]   filt;
    logic                done;
    logic                loop_mark;
    abd_end_t            end_action;
    logic                bad;
  } abd_job_t;

  function automatic logic signed [TAP_W-1:0] tap_a(input logic [FILT_W-1:0] f);
    logic signed [TAP_W-1:0] k;
    case (f)
      3'd1:    k = 8'sd60;
      3'd2:    k = 8'sd115;
      3'd3:    k = 8'sd98;
      3'd4:    k = 8'sd122;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [TAP_W-1:0] tap_b(input logic [FILT_W-1:0] f);
    logic signed [TAP_W-1:0] k;
    case (f)
      3'd2:    k = -8'sd52;
      3'd3:    k = -8'sd55;
      3'd4:    k = -8'sd60;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

  // Only flag bits 0 and 1 pick the end action
  function automatic abd_end_t end_code(input logic [7:0] flags);
    abd_end_t e;
    if (!flags[0]) begin
      e = END_CONTINUE;
    end else if (flags[1]) begin
      e = END_LOOP;
    end else begin
      e = END_STOP;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/abd_if.sv =====
// Interfaces: input, result and configuration channels of the ADPCM block decoder.
`default_nettype none
interface abd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] block_byte;
  modport source (output valid, output cmd, output block_byte, input ready);
  modport sink   (input valid, input cmd, input block_byte, output ready);
endinterface

interface abd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic               block_done;
  logic               loop_mark;
  logic [1:0]         end_action;
  logic               bad_filter;
  modport source (output valid, output sample, output last, output block_done,
                  output loop_mark, output end_action, output bad_filter, input ready);
  modport sink   (input valid, input sample, input last, input block_done,
                  input loop_mark, input end_action, input bad_filter, output ready);
endinterface

interface abd_cfg_if;
  logic valid;
  logic ready;
  logic output_enable;
  modport source (output valid, output output_enable, input ready);
  modport sink   (input valid, input output_enable, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/abd_parser.sv =====
// Block parser: tracks byte position, header and flags, and holds the data byte in work.
`default_nettype none
module abd_parser
  import abd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_xfer,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_byte,
  input  wire logic       adv,
  output logic            restart,
  output abd_job_t        job
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [FILT_W-1:0]  filt_r, filt_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic               bad_r, bad_nxt;
  abd_job_t           job_r, job_nxt;

  assign restart = in_xfer && (in_cmd == CMD_RESTART);
  assign job     = job_r;

  always_comb begin
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    filt_nxt  = filt_r;
    flags_nxt = flags_r;
    bad_nxt   = bad_r;
    job_nxt   = job_r;

    // advance the byte in work: low nibble, then high nibble, then drop
    if (adv && job_r.valid) begin
      if (!job_r.phase) begin
        job_nxt.phase = 1'b1;
      end else begin
        job_nxt.valid = 1'b0;
      end
    end

    if (restart) begin
      pos_nxt   = '0;
      shift_nxt = '0;
      filt_nxt  = '0;
      flags_nxt = '0;
      bad_nxt   = 1'b0;
    end else if (in_xfer) begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (pos_r)
        POS_HEADER: begin
          shift_nxt = in_byte[3:0];
          bad_nxt   = (in_byte[7:4] > {1'b0, FILT_MAX});
          filt_nxt  = bad_nxt ? '0 : in_byte[6:4];
        end
        POS_FLAGS: begin
          flags_nxt = in_byte;
        end
        default: begin
          job_nxt.valid      = 1'b1;
          job_nxt.phase      = 1'b0;
          job_nxt.data       = in_byte;
          job_nxt.shift      = shift_r;
          job_nxt.filt       = filt_r;
          job_nxt.done       = (pos_r == POS_LAST);
          job_nxt.loop_mark  = flags_r[2];
          job_nxt.end_action = end_code(flags_r);
          job_nxt.bad        = bad_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      shift_r     <= '0;
      filt_r      <= '0;
      flags_r     <= '0;
      bad_r       <= 1'b0;
      job_r.valid <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      filt_r  <= filt_nxt;
      flags_r <= flags_nxt;
      bad_r   <= bad_nxt;
      job_r   <= job_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/abd_predict.sv =====
// Nibble decoder: scale, two-tap prediction, saturation and the history registers.
`default_nettype none
module abd_predict
  import abd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire abd_job_t                 job,
  input  wire logic                     step,
  input  wire logic                     clear,
  output logic signed [SAMP_W-1:0]      fa
);

  logic signed [SAMP_W-1:0] h1_r, h1_nxt;
  logic signed [SAMP_W-1:0] h2_r, h2_nxt;

  logic [3:0]                        nib;
  logic signed [SAMP_W-1:0]          scaled;
  logic signed [SAMP_W-1:0]          base;
  logic signed [PROD_W-1:0]          pa;
  logic signed [PROD_W-1:0]          pb;
  logic signed [PROD_W-PRED_SH-1:0]  pa_s;
  logic signed [PROD_W-PRED_SH-1:0]  pb_s;
  logic signed [SUM_W-1:0]           sum;

  always_comb begin
    nib    = job.phase ? job.data[7:4] : job.data[3:0];
    scaled = $signed({nib, 12'h000});
    base   = scaled >>> job.shift;
    pa     = PROD_W'(h1_r) * PROD_W'(tap_a(job.filt));
    pb     = PROD_W'(h2_r) * PROD_W'(tap_b(job.filt));
    // floor divide by 64: drop the low bits of each product
    pa_s   = $signed(pa[PROD_W-1:PRED_SH]);
    pb_s   = $signed(pb[PROD_W-1:PRED_SH]);
    sum    = $signed({{(SUM_W-SAMP_W){base[SAMP_W-1]}}, base})
           + $signed({{(SUM_W-(PROD_W-PRED_SH)){pa_s[PROD_W-PRED_SH-1]}}, pa_s})
           + $signed({{(SUM_W-(PROD_W-PRED_SH)){pb_s[PROD_W-PRED_SH-1]}}, pb_s});
    if (sum > SUM_MAX) begin
      fa = SAMP_MAX;
    end else if (sum < SUM_MIN) begin
      fa = SAMP_MIN;
    end else begin
      fa = sum[SAMP_W-1:0];
    end
  end

  always_comb begin
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    if (clear) begin
      h1_nxt = '0;
      h2_nxt = '0;
    end else if (step) begin
      h2_nxt = h1_r;
      h1_nxt = fa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= '0;
      h2_r <= '0;
    end else begin
      h1_r <= h1_nxt;
      h2_r <= h2_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/adpcm_block_sample_decoder.sv =====
// Top level of the voice ADPCM block decoder: channels, output register and config.
//
// Usage:
//   in_bus  : one transfer per stream byte (cmd, block_byte). cmd = restart clears the
//             history, the block position, shift, filter and flags; it gives no result.
//   out_bus : one transfer per decoded sample. Each data byte gives two samples, low
//             nibble first; the header and flags bytes give none.
//   cfg_bus : writes output_enable; always ready. Write it only while the block is idle.
// Path: a data byte is held in the parser's job register, and each of its nibbles is
//   decoded combinationally and loaded into the output register, low nibble first.
// Throughput: one nibble is decoded per cycle while the output register can advance,
//   through a single scale, predict and saturate stage; header and flags bytes give none.
//   in_ready stays high while the last nibble of the byte in work is leaving.
// Reset (rst_n low, synchronous): history, position, header state, output_enable and
//   all valid flags clear.
// Stall: while out_bus.ready is low the output register holds its sample, the byte in
//   work holds its nibble, and in_bus.ready drops once a data byte is waiting.
`default_nettype none
module adpcm_block_sample_decoder
  import abd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  abd_in_if.sink      in_bus,
  abd_out_if.source   out_bus,
  abd_cfg_if.sink     cfg_bus
);

  abd_job_t                 job;
  logic                     restart;
  logic                     adv;
  logic                     in_xfer;
  logic                     step;
  logic signed [SAMP_W-1:0] fa;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [SAMP_W-1:0] sample_r, sample_nxt;
  logic                     last_r, done_r, loop_r, bad_r;
  abd_end_t                 end_r;
  logic                     enable_r;

  // The output register can take a sample when empty or being drained this cycle
  assign adv     = !out_valid_r || out_bus.ready;
  assign step    = adv && job.valid;
  // Take a new byte when no nibble would be left behind
  assign in_bus.ready = !job.valid || (job.phase && adv);
  assign in_xfer = in_bus.valid && in_bus.ready;

  assign cfg_bus.ready = 1'b1;

  abd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_xfer (in_xfer),
    .in_cmd  (in_bus.cmd),
    .in_byte (in_bus.block_byte),
    .adv     (adv),
    .restart (restart),
    .job     (job)
  );

  abd_predict u_predict (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job),
    .step  (step),
    .clear (restart),
    .fa    (fa)
  );

  // Output sample: zero when disabled, else keep off the most negative code
  always_comb begin
    if (!enable_r) begin
      sample_nxt = '0;
    end else if (fa == SAMP_MIN) begin
      sample_nxt = SAMP_OUT_MIN;
    end else begin
      sample_nxt = fa;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      enable_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_bus.valid) begin
        enable_r <= cfg_bus.output_enable;
      end
    end
  end

  // Payload: load on every step, no reset needed
  always_ff @(posedge clk) begin
    if (step) begin
      sample_r <= sample_nxt;
      last_r   <= job.phase;
      done_r   <= job.phase && job.done;
      loop_r   <= job.phase && job.done && job.loop_mark;
      end_r    <= (job.phase && job.done) ? job.end_action : END_CONTINUE;
      bad_r    <= job.bad;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.sample     = sample_r;
  assign out_bus.last       = last_r;
  assign out_bus.block_done = done_r;
  assign out_bus.loop_mark  = loop_r;
  assign out_bus.end_action = end_r;
  assign out_bus.bad_filter = bad_r;

  // A byte is never taken while its predecessor still has a nibble to go
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (!job.valid || (job.phase && adv)))
    else $error("input byte taken over a pending nibble");

  // A new sample appears only from a byte in work
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(job.valid))
    else $error("output valid without a byte in work");

  // Block end is reported only on a high-nibble sample
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("block end on a low-nibble sample");

  // The most negative code never leaves the block
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (sample_r != SAMP_MIN))
    else $error("sample not clamped");

endmodule
`default_nettype wire

// ===== tb/sv/abd_decode_checker.sv =====
`timescale 1ns / 100ps
// Checker: watches the decoder channels, predicts each decoded sample and compares it.
module abd_decode_checker
  import abd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  abd_in_if         in_mon,
  abd_out_if        out_mon,
  abd_cfg_if        cfg_mon,
  output int        mismatches,
  output int        pending
);

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               block_done;
    logic               loop_mark;
    abd_end_t           end_action;
    logic               bad_filter;
  } sample_rec_t;

  sample_rec_t expected_samples[$];

  // Decoder state as the block should hold it
  logic signed [15:0] hist_one, hist_two;
  logic [3:0]         byte_pos, shift_amt;
  logic [2:0]         filt_sel;
  logic [7:0]         blk_flags;
  logic               filt_bad;
  logic               out_en;
  int                 mismatch_count;

  // Scale one nibble, add the two-tap prediction and saturate to 16 bits
  function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib,
                                                       input logic [3:0] sh,
                                                       input logic [2:0] f,
                                                       input logic signed [15:0] h1,
                                                       input logic signed [15:0] h2);
    logic signed [15:0] scaled;
    int k0, k1, sum;
    scaled = $signed({nib, 12'h000}) >>> sh;
    case (f)
      3'd1:    begin k0 = 60;  k1 = 0;   end
      3'd2:    begin k0 = 115; k1 = -52; end
      3'd3:    begin k0 = 98;  k1 = -55; end
      3'd4:    begin k0 = 122; k1 = -60; end
      default: begin k0 = 0;   k1 = 0;   end
    endcase
    sum = int'(scaled) + ((int'(h1) * k0) >>> 6) + ((int'(h2) * k1) >>> 6);
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return 16'(sum);
  endfunction

  function automatic sample_rec_t sample_record(input logic signed [15:0] hist,
                                                input logic second, input logic done);
    sample_rec_t r;
    r.sample     = 16'sd0;
    if (out_en) r.sample = (hist == SAMP_MIN) ? SAMP_OUT_MIN : hist;
    r.last       = second;
    r.block_done = done;
    r.loop_mark  = done & blk_flags[2];
    if (done && blk_flags[0]) r.end_action = blk_flags[1] ? END_LOOP : END_STOP;
    else r.end_action = END_CONTINUE;
    r.bad_filter = filt_bad;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] sample check: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    logic [3:0]         cur_pos;
    logic [7:0]         b;
    logic signed [15:0] lo, hi;
    sample_rec_t        got, want;
    if (!rst_n) begin
      hist_one = '0; hist_two = '0; byte_pos = '0; shift_amt = '0;
      filt_sel = '0; blk_flags = '0; filt_bad = 1'b0; out_en = 1'b0;
      mismatch_count = 0;
      expected_samples.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) out_en = cfg_mon.output_enable;

      if (in_mon.valid && in_mon.ready) begin
        b = in_mon.block_byte;
        if (in_mon.cmd == CMD_RESTART) begin
          hist_one = '0; hist_two = '0; byte_pos = '0; shift_amt = '0;
          filt_sel = '0; blk_flags = '0; filt_bad = 1'b0;
        end else begin
          cur_pos  = byte_pos;
          byte_pos = byte_pos + 4'd1;
          if (cur_pos == POS_HEADER) begin
            shift_amt = b[3:0];
            filt_bad  = b[7:4] > FILT_MAX;
            filt_sel  = filt_bad ? 3'd0 : b[6:4];
          end else if (cur_pos == POS_FLAGS) begin
            blk_flags = b;
          end else begin
            // low nibble first, each feeding the history of the next
            lo = decode_nibble(b[3:0], shift_amt, filt_sel, hist_one, hist_two);
            hist_two = hist_one; hist_one = lo;
            hi = decode_nibble(b[7:4], shift_amt, filt_sel, hist_one, hist_two);
            hist_two = hist_one; hist_one = hi;
            expected_samples.push_back(sample_record(lo, 1'b0, 1'b0));
            expected_samples.push_back(sample_record(hi, 1'b1, cur_pos == POS_LAST));
          end
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        got.sample     = out_mon.sample;
        got.last       = out_mon.last;
        got.block_done = out_mon.block_done;
        got.loop_mark  = out_mon.loop_mark;
        got.end_action = abd_end_t'(out_mon.end_action);
        got.bad_filter = out_mon.bad_filter;
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", got.sample));
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample || got.last !== want.last ||
              got.block_done !== want.block_done || got.loop_mark !== want.loop_mark ||
              got.end_action !== want.end_action || got.bad_filter !== want.bad_filter)
            report_mismatch($sformatf(
              "got s=%0d l=%b d=%b m=%b e=%0d b=%b, want s=%0d l=%b d=%b m=%b e=%0d b=%b",
              got.sample, got.last, got.block_done, got.loop_mark, got.end_action,
              got.bad_filter, want.sample, want.last, want.block_done, want.loop_mark,
              want.end_action, want.bad_filter));
        end
      end
    end
    mismatches <= mismatch_count;
    pending    <= expected_samples.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus, flow control and verdict for the ADPCM decoder.
module tb_top
  import abd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 300;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_ITEM = 400;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   items_sent;
  int   mismatches;
  int   pending;
  bit   tx_idle;
  bit   rx_idle;
  bit   long_hold;

  abd_in_if  in_ch();
  abd_out_if out_ch();
  abd_cfg_if cfg_ch();

  adpcm_block_sample_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  abd_decode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a sample that never arrives ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("adpcm_block_sample_decoder regression: fail");
      $finish;
    end
  end

  // Offer one stream byte, optionally after a random idle burst, and hold it
  // until the transfer happens.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.block_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted sample has come out, then give
  // trailing header or restart bytes time to clear the pipe.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enable(input logic en);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.output_enable <= en;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Directed part: one full block with the strongest filter driven into both
  // saturation rails and ending in a loop jump with the loop mark set, then a
  // block with an out-of-range filter and the largest shift, cut by a restart.
  task automatic run_directed();
    logic [7:0] data_seq [14] = '{8'h77, 8'h77, 8'h77, 8'h77, 8'h88, 8'h88, 8'h88,
                                  8'h88, 8'hff, 8'h00, 8'h7f, 8'hf7, 8'h80, 8'h08};
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_STREAM, 8'h40);
    send_item(CMD_STREAM, 8'h07);
    for (int i = 0; i < 14; i++) send_item(CMD_STREAM, data_seq[i]);
    send_item(CMD_RESTART, 8'hff);
    send_item(CMD_STREAM, 8'hff);
    send_item(CMD_STREAM, 8'h01);
    send_item(CMD_STREAM, 8'h87);
    send_item(CMD_STREAM, 8'h78);
    send_item(CMD_RESTART, 8'h5a);
  endtask

  // One well-formed block with random content; now and then cut short by a
  // restart at a random byte, which also yields stray restarts between blocks.
  task automatic send_block();
    logic [3:0] filt_num, shift_amt;
    int cut;
    filt_num  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(5, 15))
                                            : 4'($urandom_range(0, 4));
    shift_amt = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : 16;
    for (int i = 0; i < 16; i++) begin
      if (i == cut) begin
        send_item(CMD_RESTART, 8'($urandom_range(0, 255)));
        return;
      end
      if (i == 0) send_item(CMD_STREAM, {filt_num, shift_amt});
      else send_item(CMD_STREAM, 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: random ready-low bursts when enabled, forced low during the
  // long hold. Ready gets exactly one assignment per edge.
  initial begin
    int burst_left;
    burst_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (burst_left == 0 && rx_idle && $urandom_range(0, 5) == 0)
        burst_left = $urandom_range(1, 14);
      if (burst_left > 0) begin
        burst_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !long_hold;
      end
    end
  end

  // Long hold: stall the receiver once while the sender keeps offering bytes,
  // so the decoder fills and drops in_ready.
  initial begin
    long_hold = 1'b0;
    wait (items_sent >= HOLD_AT_ITEM);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Main sequence
  initial begin
    bit tx_plan [PHASES] = '{1, 0, 1, 1, 1, 0};
    bit rx_plan [PHASES] = '{1, 1, 1, 0, 1, 0};
    bit en_plan [PHASES] = '{1, 1, 0, 1, 1, 1};
    int target;
    cycle_count          = 0;
    items_sent           = 0;
    tx_idle              = 1'b0;
    rx_idle              = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_STREAM;
    in_ch.block_byte     = 8'h00;
    cfg_ch.valid         = 1'b0;
    cfg_ch.output_enable = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_enable(1'b1);
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      // reconfigure only with the block idle
      wait_drained();
      write_enable(en_plan[p]);
      tx_idle = tx_plan[p];
      rx_idle <= rx_plan[p];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_block();
    end

    wait_drained();
    if (mismatches == 0)
      $display("adpcm_block_sample_decoder regression: pass");
    else
      $display("adpcm_block_sample_decoder regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/abd_pkg.sv
rtl/core/abd_if.sv
rtl/core/abd_parser.sv
rtl/core/abd_predict.sv
rtl/core/adpcm_block_sample_decoder.sv
tb/sv/abd_decode_checker.sv
tb/sv/tb_top.sv
